### hw/rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths, the line command type and a small helper for the line pixel
// stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int COORD_LIMIT = 32;
  localparam int COORD_W     = 5;
  localparam int RW_W        = 6;
  localparam int ADDR_W      = 10;
  localparam int COLOUR_W    = 32;
  localparam int CNT_W       = 6;
  localparam int ERR_W       = 8;
  localparam int PROD_W      = COORD_W + RW_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_WIDTH = 1'b0;

  localparam logic [RW_W-1:0] ROW_WIDTH_RESET = RW_W'(32);

  // classified line command as it sits in the queue
  typedef struct packed {
    logic [COORD_W-1:0]      x0;
    logic [COORD_W-1:0]      y0;
    logic [COORD_W-1:0]      dx;
    logic [COORD_W-1:0]      dy;
    logic                    x_neg;
    logic                    y_neg;
    logic signed [ERR_W-1:0] err;
    logic [CNT_W-1:0]        count;
    logic [COLOUR_W-1:0]     colour;
  } lps_cmd_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } lps_qstat_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] lim;
    lim = COORD_W'(COORD_LIMIT - 1);
    return (v > lim) ? lim : v;
  endfunction

endpackage

### hw/rtl/lps_front.sv
// ----------------------------------------------------------------------------
// lps_front
// Accepts line commands, bounds the end points and works out deltas,
// directions, the starting error and the pixel count.
// ----------------------------------------------------------------------------
module lps_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lps_pkg::COORD_W-1:0]  start_x,
  input  logic [lps_pkg::COORD_W-1:0]  start_y,
  input  logic [lps_pkg::COORD_W-1:0]  end_x,
  input  logic [lps_pkg::COORD_W-1:0]  end_y,
  input  logic [lps_pkg::COLOUR_W-1:0] colour,
  input  lps_pkg::lps_qstat_t          qstat,
  output logic                         push,
  output lps_pkg::lps_cmd_t            cmd
);

  logic [lps_pkg::COORD_W-1:0] x0, y0, x1, y1;
  logic                        x_up, y_up;

  always_comb begin
    x0   = lps_pkg::clamp_coord(start_x);
    y0   = lps_pkg::clamp_coord(start_y);
    x1   = lps_pkg::clamp_coord(end_x);
    y1   = lps_pkg::clamp_coord(end_y);
    x_up = x1 > x0;
    y_up = y1 > y0;

    cmd.x0     = x0;
    cmd.y0     = y0;
    cmd.dx     = x_up ? (x1 - x0) : (x0 - x1);
    cmd.dy     = y_up ? (y1 - y0) : (y0 - y1);
    cmd.x_neg  = !x_up;
    cmd.y_neg  = !y_up;
    cmd.err    = $signed(lps_pkg::ERR_W'(cmd.dx)) - $signed(lps_pkg::ERR_W'(cmd.dy));
    cmd.count  = lps_pkg::CNT_W'(cmd.dx) + lps_pkg::CNT_W'(cmd.dy) + lps_pkg::CNT_W'(1);
    cmd.colour = colour;
  end

  assign in_ready = !qstat.full;
  assign push     = in_valid && !qstat.full;

endmodule

### hw/rtl/lps_queue.sv
// ----------------------------------------------------------------------------
// lps_queue
// Short command queue between the front and the stepper.
// ----------------------------------------------------------------------------
module lps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lps_pkg::lps_cmd_t push_cmd,
  input  logic              pop,
  output lps_pkg::lps_cmd_t head,
  output lps_pkg::lps_qstat_t qstat
);

  lps_pkg::lps_cmd_t             entries [lps_pkg::QUEUE_DEPTH];
  logic [lps_pkg::QPTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [lps_pkg::QPTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [lps_pkg::QFILL_W-1:0]   fill, fill_next;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_next   = fill;
    if (push) begin
      wr_ptr_next = (wr_ptr == lps_pkg::QPTR_W'(lps_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr + lps_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == lps_pkg::QPTR_W'(lps_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr + lps_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_next = fill + lps_pkg::QFILL_W'(1);
    end else if (pop && !push) begin
      fill_next = fill - lps_pkg::QFILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign head        = entries[rd_ptr];
  assign qstat.full  = fill == lps_pkg::QFILL_W'(lps_pkg::QUEUE_DEPTH);
  assign qstat.valid = fill != '0;

endmodule

### hw/rtl/lps_back.sv
// ----------------------------------------------------------------------------
// lps_back
// Line stepper: walks one command a pixel per cycle, when the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module lps_back (
  input  logic                         clk,
  input  logic                         rst,
  input  lps_pkg::lps_cmd_t            head,
  input  lps_pkg::lps_qstat_t          qstat,
  output logic                         pop,
  input  logic [lps_pkg::RW_W-1:0]     row_width,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lps_pkg::COORD_W-1:0]  pixel_x,
  output logic [lps_pkg::COORD_W-1:0]  pixel_y,
  output logic [lps_pkg::ADDR_W-1:0]   pixel_address,
  output logic [lps_pkg::COLOUR_W-1:0] pixel_colour,
  output logic                         last_pixel
);

  logic                          busy;
  logic [lps_pkg::COORD_W-1:0]   px, py, px_next, py_next;
  logic [lps_pkg::COORD_W-1:0]   dx, dy;
  logic                          x_neg, y_neg;
  logic signed [lps_pkg::ERR_W-1:0] err, err_next;
  logic [lps_pkg::CNT_W-1:0]     remain;
  logic [lps_pkg::COLOUR_W-1:0]  colour;
  logic                          adv, final_step;
  logic [lps_pkg::PROD_W-1:0]    addr_full;

  assign adv        = busy && (!out_valid || out_ready);
  assign final_step = adv && (remain == lps_pkg::CNT_W'(1));
  assign pop        = qstat.valid && (!busy || final_step);

  // positive error steps in x, otherwise (ties too) in y
  always_comb begin
    px_next  = px;
    py_next  = py;
    err_next = err;
    if (err > 0) begin
      px_next  = x_neg ? px - lps_pkg::COORD_W'(1) : px + lps_pkg::COORD_W'(1);
      err_next = err - $signed(lps_pkg::ERR_W'({dy, 1'b0}));
    end else begin
      py_next  = y_neg ? py - lps_pkg::COORD_W'(1) : py + lps_pkg::COORD_W'(1);
      err_next = err + $signed(lps_pkg::ERR_W'({dx, 1'b0}));
    end
    addr_full = lps_pkg::PROD_W'(py) * lps_pkg::PROD_W'(row_width)
              + lps_pkg::PROD_W'(px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (final_step) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      px     <= head.x0;
      py     <= head.y0;
      dx     <= head.dx;
      dy     <= head.dy;
      x_neg  <= head.x_neg;
      y_neg  <= head.y_neg;
      err    <= head.err;
      remain <= head.count;
      colour <= head.colour;
    end else if (adv) begin
      px     <= px_next;
      py     <= py_next;
      err    <= err_next;
      remain <= remain - lps_pkg::CNT_W'(1);
    end
    if (adv) begin
      pixel_x       <= px;
      pixel_y       <= py;
      pixel_address <= addr_full[lps_pkg::ADDR_W-1:0];
      pixel_colour  <= colour;
      last_pixel    <= remain == lps_pkg::CNT_W'(1);
    end
  end

endmodule

### hw/rtl/line_pixel_stepper_top.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper_top
// Four-connected line rasterizer with an APB stride register.
// ----------------------------------------------------------------------------
// A line command of n = 1 + |dx| + |dy| pixels (1 to 63) occupies the stepper
// with one pixel write per cycle when the output is not stalled; the stepper
// is the only multi-cycle part. Commands are classified on entry and wait in a
// two-entry queue, so the next command is taken into the stepper on the cycle
// its predecessor emits its last pixel and lines follow without a gap. The
// first pixel of a command accepted into an empty block passes the queue, the
// stepper registers and the output register. row_width sits at byte address 0
// and should only be written while no line is in flight.
module line_pixel_stepper_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lps_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lps_pkg::COORD_W-1:0]     start_x,
  input  logic [lps_pkg::COORD_W-1:0]     start_y,
  input  logic [lps_pkg::COORD_W-1:0]     end_x,
  input  logic [lps_pkg::COORD_W-1:0]     end_y,
  input  logic [lps_pkg::COLOUR_W-1:0]    colour,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lps_pkg::COORD_W-1:0]     pixel_x,
  output logic [lps_pkg::COORD_W-1:0]     pixel_y,
  output logic [lps_pkg::ADDR_W-1:0]      pixel_address,
  output logic [lps_pkg::COLOUR_W-1:0]    pixel_colour,
  output logic                            last_pixel
);

  logic [lps_pkg::RW_W-1:0] row_width;
  logic                     push, pop;
  lps_pkg::lps_cmd_t        push_cmd, head;
  lps_pkg::lps_qstat_t      qstat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= lps_pkg::ROW_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == lps_pkg::REG_ROW_WIDTH)) begin
      row_width <= pwdata[lps_pkg::RW_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lps_pkg::REG_ROW_WIDTH) begin
      prdata = lps_pkg::APB_DATA_W'(row_width);
    end
  end

  lps_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .colour   (colour),
    .qstat    (qstat),
    .push     (push),
    .cmd      (push_cmd)
  );

  lps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  lps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .row_width     (row_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_colour  (pixel_colour),
    .last_pixel    (last_pixel)
  );

endmodule

### hw/rtl/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks for the line pixel stepper, bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [lps_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [lps_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [lps_pkg::APB_DATA_W-1:0]  prdata,
  input logic                            pready,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [lps_pkg::COORD_W-1:0]     start_x,
  input logic [lps_pkg::COORD_W-1:0]     start_y,
  input logic [lps_pkg::COORD_W-1:0]     end_x,
  input logic [lps_pkg::COORD_W-1:0]     end_y,
  input logic [lps_pkg::COLOUR_W-1:0]    colour,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lps_pkg::COORD_W-1:0]     pixel_x,
  input logic [lps_pkg::COORD_W-1:0]     pixel_y,
  input logic [lps_pkg::ADDR_W-1:0]      pixel_address,
  input logic [lps_pkg::COLOUR_W-1:0]    pixel_colour,
  input logic                            last_pixel
);

  logic [lps_pkg::RW_W-1:0]    rw;
  logic [lps_pkg::COORD_W-1:0] prev_x, prev_y, step_x, step_y;
  logic                        mid_line;
  logic [lps_pkg::PROD_W-1:0]  addr_exp;
  logic                        unused_ok;

  // shadow of the stride register
  always_ff @(posedge clk) begin
    if (rst) begin
      rw <= lps_pkg::ROW_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == lps_pkg::REG_ROW_WIDTH)) begin
      rw <= pwdata[lps_pkg::RW_W-1:0];
    end
  end

  // last transaction seen on the output, and whether a line is still open
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_line <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_line <= !last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_x <= pixel_x;
      prev_y <= pixel_y;
    end
  end

  always_comb begin
    step_x    = pixel_x - prev_x;
    step_y    = pixel_y - prev_y;
    addr_exp  = lps_pkg::PROD_W'(pixel_y) * lps_pkg::PROD_W'(rw)
              + lps_pkg::PROD_W'(pixel_x);
    unused_ok = (|prdata) || in_valid || in_ready || (|start_x) || (|start_y) ||
                (|end_x) || (|end_y) || (|colour);
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output valid or input stall right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({pixel_x, pixel_y, pixel_address, pixel_colour, last_pixel}))
    else $error("stalled pixel transaction changed");

  a_address: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_address == addr_exp[lps_pkg::ADDR_W-1:0])
    else $error("pixel address does not match coordinates and stride");

  a_unit_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid_line |->
      ((step_y == '0) && ((step_x == lps_pkg::COORD_W'(1)) || (step_x == '1))) ||
      ((step_x == '0) && ((step_y == lps_pkg::COORD_W'(1)) || (step_y == '1))))
    else $error("consecutive pixels of a line are not four-connected");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel |-> pready || unused_ok)
    else $error("apb access stalled");

endmodule

bind line_pixel_stepper_top lps_checker u_lps_checker (.*);
